// ----- rtl/core/i2cmb_pkg.sv -----
// Types and event codes shared by the I2C slave mailbox design.
`default_nettype none

package i2cmb_pkg;

    localparam logic [2:0] REQ_ADDR_WRITE = 3'd0;
    localparam logic [2:0] REQ_ADDR_READ  = 3'd1;
    localparam logic [2:0] REQ_RX_BYTE    = 3'd2;
    localparam logic [2:0] REQ_TX_REQUEST = 3'd3;
    localparam logic [2:0] REQ_STOP       = 3'd4;
    localparam logic [2:0] REQ_HOST_READ  = 3'd5;
    localparam logic [2:0] REQ_HOST_CLEAR = 3'd6;

    localparam logic [7:0] TX_IDLE_BYTE = 8'hFF;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] bus_byte;
        logic [1:0] buffer_index;
        logic [4:0] byte_offset;
    } cmd_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       mailbox_ready;
        logic       byte_stored;
    } result_t;

    typedef enum logic [1:0] {
        SRC_ZERO = 2'd0,
        SRC_IDLE = 2'd1,
        SRC_MEM  = 2'd2
    } data_src_t;

endpackage

`default_nettype wire

// ----- rtl/core/i2c_slave_indexed_mailbox_top.sv -----
// I2C slave indexed mailbox: event decode, mailbox state and byte store.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------
//  command   | start / busy       | cmd    (req_type, bus_byte, buffer_index,
//            |                    |         byte_offset)
//  result    | done (one cycle)   | result (data_byte, mailbox_ready,
//            |                    |         byte_stored)
//
//  One command per cycle; busy is always low.
//  Each command passes through the command register and then the registered
//  read of the byte store before its result is given.
//  Mailbox state and the store are updated at the end of the command cycle, so
//  back-to-back commands see each other's effects in order.
//  Reset clears selection, write position and ready flags; the store is not
//  cleared. The receiver cannot stall; results are never held.
`default_nettype none

module i2c_slave_indexed_mailbox_top
    import i2cmb_pkg::*;
#(
    parameter int MAILBOX_COUNT = 4,
    parameter int MAILBOX_BYTES = 31
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire cmd_t    cmd,
    output logic         done,
    output result_t      result
);

    localparam int STRIDE = MAILBOX_BYTES + 1;
    localparam int DEPTH  = MAILBOX_COUNT * STRIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SEL_W  = $clog2(MAILBOX_COUNT + 1);
    localparam int IDX_W  = (MAILBOX_COUNT > 1) ? $clog2(MAILBOX_COUNT) : 1;
    localparam int OFF_W  = $clog2(MAILBOX_BYTES + 1);

    logic                     s1_valid_reg;
    cmd_t                     s1_cmd_reg;
    logic                     s2_valid_reg;
    data_src_t                s2_src_reg;
    data_src_t                s2_src_next;
    logic                     s2_rdy_reg;
    logic                     s2_rdy_next;
    logic                     s2_stored_reg;
    logic                     s2_stored_next;

    logic [SEL_W-1:0]         sel_reg;
    logic [SEL_W-1:0]         sel_next;
    logic                     pv_reg;
    logic                     pv_next;
    logic [OFF_W-1:0]         off_reg;
    logic [OFF_W-1:0]         off_next;
    logic [MAILBOX_COUNT-1:0] ready_reg;
    logic [MAILBOX_COUNT-1:0] ready_next;

    logic [7:0]               mem [DEPTH];
    logic [7:0]               mem_rd_reg;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_addr;
    logic [7:0]               mem_wdata;

    logic [IDX_W-1:0]         sel_idx;
    logic [IDX_W-1:0]         rx_idx;
    logic [IDX_W-1:0]         host_idx;
    logic [ADDR_W-1:0]        pos_addr;
    logic [ADDR_W-1:0]        host_addr;
    logic                     rx_in_range;
    logic                     host_in_range;
    logic                     hoff_in_range;

    assign busy = 1'b0;

    assign sel_idx       = IDX_W'(sel_reg - SEL_W'(1));
    assign rx_idx        = IDX_W'(s1_cmd_reg.bus_byte - 8'd1);
    assign host_idx      = IDX_W'(s1_cmd_reg.buffer_index);
    assign rx_in_range   = 32'(s1_cmd_reg.bus_byte) inside {[1 : MAILBOX_COUNT]};
    assign host_in_range = 32'(s1_cmd_reg.buffer_index) < MAILBOX_COUNT;
    assign hoff_in_range = 32'(s1_cmd_reg.byte_offset) < STRIDE;
    assign pos_addr      = ADDR_W'(ADDR_W'(sel_idx) * ADDR_W'(STRIDE))
                         + ADDR_W'(off_reg);
    assign host_addr     = ADDR_W'(ADDR_W'(host_idx) * ADDR_W'(STRIDE))
                         + ADDR_W'(s1_cmd_reg.byte_offset);

    always_comb
    begin
        sel_next       = sel_reg;
        pv_next        = pv_reg;
        off_next       = off_reg;
        ready_next     = ready_reg;
        mem_we         = 1'b0;
        mem_addr       = pos_addr;
        mem_wdata      = s1_cmd_reg.bus_byte;
        s2_src_next    = SRC_ZERO;
        s2_rdy_next    = 1'b0;
        s2_stored_next = 1'b0;
        if (s1_valid_reg)
        begin
            case (s1_cmd_reg.req_type)
                REQ_ADDR_WRITE:
                begin
                    sel_next = '0;
                    pv_next  = 1'b0;
                    off_next = '0;
                end
                REQ_RX_BYTE:
                begin
                    if (sel_reg == '0 && !pv_reg)
                    begin
                        if (rx_in_range)
                        begin
                            sel_next = SEL_W'(s1_cmd_reg.bus_byte);
                            if (!ready_reg[rx_idx])
                            begin
                                pv_next        = 1'b1;
                                off_next       = '0;
                                s2_stored_next = 1'b1;
                            end
                        end
                    end
                    else if (pv_reg && 32'(off_reg) < MAILBOX_BYTES)
                    begin
                        mem_we         = 1'b1;
                        off_next       = off_reg + OFF_W'(1);
                        s2_stored_next = 1'b1;
                    end
                end
                REQ_TX_REQUEST:
                begin
                    s2_src_next = pv_reg ? SRC_MEM : SRC_IDLE;
                end
                REQ_STOP:
                begin
                    if (pv_reg)
                    begin
                        mem_we              = 1'b1;
                        mem_wdata           = 8'd0;
                        ready_next[sel_idx] = 1'b1;
                    end
                end
                REQ_HOST_READ:
                begin
                    mem_addr = host_addr;
                    if (host_in_range)
                    begin
                        s2_rdy_next = ready_reg[host_idx];
                        if (hoff_in_range)
                        begin
                            s2_src_next = SRC_MEM;
                        end
                    end
                end
                REQ_HOST_CLEAR:
                begin
                    if (host_in_range)
                    begin
                        s2_rdy_next          = ready_reg[host_idx];
                        ready_next[host_idx] = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            sel_reg      <= '0;
            pv_reg       <= 1'b0;
            off_reg      <= '0;
            ready_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            sel_reg      <= sel_next;
            pv_reg       <= pv_next;
            off_reg      <= off_next;
            ready_reg    <= ready_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            s1_cmd_reg <= cmd;
        end
        s2_src_reg    <= s2_src_next;
        s2_rdy_reg    <= s2_rdy_next;
        s2_stored_reg <= s2_stored_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rd_reg <= mem[mem_addr];
    end

    always_comb
    begin
        case (s2_src_reg)
            SRC_MEM:  result.data_byte = mem_rd_reg;
            SRC_IDLE: result.data_byte = TX_IDLE_BYTE;
            default:  result.data_byte = 8'd0;
        endcase
        result.mailbox_ready = s2_rdy_reg;
        result.byte_stored   = s2_stored_reg;
    end

    assign done = s2_valid_reg;

    a_pos_needs_sel: assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg |-> (sel_reg != '0))
        else $error("write position held with no mailbox selected");

    a_off_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(off_reg) <= MAILBOX_BYTES)
        else $error("write offset past mailbox end");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("result missing two cycles after transaction");

    a_stored_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.byte_stored) |-> (result.data_byte == 8'd0
            && !result.mailbox_ready))
        else $error("rx byte result carries data or ready flag");

endmodule

`default_nettype wire
